// File: hdl/sps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// shared types and constants of the sensor poll scheduler
// ----------------------------------------------------------------------------
package sps_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_W      = 16;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_HUMID_CYCLE    = 3'd0;
    localparam logic [2:0] REG_PRESS_CYCLE    = 3'd1;
    localparam logic [2:0] REG_AIR_PERIOD     = 3'd2;
    localparam logic [2:0] REG_TEMP_CONVERT   = 3'd3;
    localparam logic [2:0] REG_TEMP_HUMID_GAP = 3'd4;
    localparam logic [2:0] REG_HUMID_CONVERT  = 3'd5;
    localparam logic [2:0] REG_PRESS_CONVERT  = 3'd6;

    // register reset values
    localparam logic [REG_W-1:0] RST_HUMID_CYCLE    = 16'd600;
    localparam logic [REG_W-1:0] RST_PRESS_CYCLE    = 16'd300;
    localparam logic [REG_W-1:0] RST_AIR_PERIOD     = 16'd120;
    localparam logic [REG_W-1:0] RST_TEMP_CONVERT   = 16'd1;
    localparam logic [REG_W-1:0] RST_TEMP_HUMID_GAP = 16'd5;
    localparam logic [REG_W-1:0] RST_HUMID_CONVERT  = 16'd1;
    localparam logic [REG_W-1:0] RST_PRESS_CONVERT  = 16'd4;

    // counter start values after reset
    localparam int STARTUP_SENSOR = 50;
    localparam int STARTUP_AIR    = 360;

    // command codes
    localparam logic [2:0] CMD_CLOCK_READ  = 3'd0;
    localparam logic [2:0] CMD_TEMP_START  = 3'd1;
    localparam logic [2:0] CMD_TEMP_READ   = 3'd2;
    localparam logic [2:0] CMD_HUMID_START = 3'd3;
    localparam logic [2:0] CMD_HUMID_READ  = 3'd4;
    localparam logic [2:0] CMD_PRESS_START = 3'd5;
    localparam logic [2:0] CMD_PRESS_READ  = 3'd6;
    localparam logic [2:0] CMD_AIR_READ    = 3'd7;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // run mask bit positions, in emission order
    localparam int RUN_CLOCK = 0;
    localparam int RUN_HUMID = 1;
    localparam int RUN_PRESS = 2;
    localparam int RUN_AIR   = 3;

    typedef struct packed {
        logic [REG_W-1:0] humid_cycle_period;
        logic [REG_W-1:0] pressure_cycle_period;
        logic [REG_W-1:0] air_quality_period;
        logic [REG_W-1:0] temp_convert_time;
        logic [REG_W-1:0] temp_to_humid_gap;
        logic [REG_W-1:0] humid_convert_time;
        logic [REG_W-1:0] pressure_convert_time;
    } cfg_t;

    // one tick's worth of work
    typedef struct packed {
        logic [3:0] run;
        logic [2:0] humid_cmd;
        logic [2:0] press_cmd;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hdl/sensor_poll_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_poll_scheduler
// tick-driven scheduler issuing clock, temperature, humidity, pressure and air commands
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------
//  tick in   | in_valid / in_stall        | pulse_level
//  cmd out   | out_valid / out_stall      | command[2:0], last
//  config    | psel penable pwrite pready | paddr[4:0], pwdata, prdata
//
//  - a tick is taken while the queue is not full; every tick taken updates
//    the counters, and a job is queued only when something is scheduled
//  - a job gives one to four commands, one per cycle from the output
//    register while out_stall is low
//  - a four-entry job queue lets ticks keep arriving while commands drain;
//    in_stall rises only when that queue is full
//  - out_stall holds the output register and the back end, not the front
//  - reset presets counters, clears phases, queue, out_valid; no clearing pass
//
module sensor_poll_scheduler
    import sps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tick in
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  pulse_level,
    // command out
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            command,
    output logic                  last,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [REG_W-1:0] cfg_wdata;
    logic [REG_W-1:0] rd_value;

    logic       push, pop;
    job_t       push_job, head_job;
    q_status_t  q_status;

    // ------------------------------------------------------------------
    // register file: 16-bit registers at byte address 4 * index
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];
    assign cfg_wdata = pwdata[REG_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_HUMID_CYCLE:    cfg_next.humid_cycle_period    = cfg_wdata;
                REG_PRESS_CYCLE:    cfg_next.pressure_cycle_period = cfg_wdata;
                REG_AIR_PERIOD:     cfg_next.air_quality_period    = cfg_wdata;
                REG_TEMP_CONVERT:   cfg_next.temp_convert_time     = cfg_wdata;
                REG_TEMP_HUMID_GAP: cfg_next.temp_to_humid_gap     = cfg_wdata;
                REG_HUMID_CONVERT:  cfg_next.humid_convert_time    = cfg_wdata;
                REG_PRESS_CONVERT:  cfg_next.pressure_convert_time = cfg_wdata;
                default:            cfg_next = cfg_reg;  // unmapped slot ignored
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_HUMID_CYCLE:    rd_value = cfg_reg.humid_cycle_period;
            REG_PRESS_CYCLE:    rd_value = cfg_reg.pressure_cycle_period;
            REG_AIR_PERIOD:     rd_value = cfg_reg.air_quality_period;
            REG_TEMP_CONVERT:   rd_value = cfg_reg.temp_convert_time;
            REG_TEMP_HUMID_GAP: rd_value = cfg_reg.temp_to_humid_gap;
            REG_HUMID_CONVERT:  rd_value = cfg_reg.humid_convert_time;
            REG_PRESS_CONVERT:  rd_value = cfg_reg.pressure_convert_time;
            default:            rd_value = '0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W - REG_W){1'b0}}, rd_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.humid_cycle_period    <= RST_HUMID_CYCLE;
            cfg_reg.pressure_cycle_period <= RST_PRESS_CYCLE;
            cfg_reg.air_quality_period    <= RST_AIR_PERIOD;
            cfg_reg.temp_convert_time     <= RST_TEMP_CONVERT;
            cfg_reg.temp_to_humid_gap     <= RST_TEMP_HUMID_GAP;
            cfg_reg.humid_convert_time    <= RST_HUMID_CONVERT;
            cfg_reg.pressure_convert_time <= RST_PRESS_CONVERT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // front end: edge detect, counters, job build
    // ------------------------------------------------------------------
    sps_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .pulse_level (pulse_level),
        .in_stall    (in_stall),
        .cfg         (cfg_reg),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    // ------------------------------------------------------------------
    // job queue
    // ------------------------------------------------------------------
    sps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    // ------------------------------------------------------------------
    // back end: while out_stall is low, one command per cycle into the output register
    // ------------------------------------------------------------------
    sps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .command   (command),
        .last      (last)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a job is never offered to a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("job pushed into full queue");

    // the back end only pulls when a job is waiting
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job popped from empty queue");

    // a clock read is always the first command of its tick
    a_clock_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=>
            !(out_valid && command == CMD_CLOCK_READ))
        else $error("clock read issued in the middle of a tick");

    // intake never stalls while the job queue is empty
    a_empty_queue_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !in_stall)
        else $error("intake stalled with an empty queue");

endmodule

// File: hdl/sps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_front
// tick intake: edge detect, subtask counters, job build
// ----------------------------------------------------------------------------
module sps_front
    import sps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      pulse_level,
    output logic      in_stall,
    input  cfg_t      cfg,
    input  q_status_t q_status,
    output logic      push,
    output job_t      push_job
);

    localparam logic [1:0] HPH_TEMP_START  = 2'd0;
    localparam logic [1:0] HPH_TEMP_READ   = 2'd1;
    localparam logic [1:0] HPH_HUMID_START = 2'd2;
    localparam logic [1:0] HPH_HUMID_READ  = 2'd3;

    localparam logic PPH_START = 1'b0;
    localparam logic PPH_READ  = 1'b1;

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;

    logic                   pulse_prev_reg, pulse_prev_next;
    logic [1:0]             humid_phase_reg, humid_phase_next;
    logic                   press_phase_reg, press_phase_next;
    logic [COUNT_WIDTH-1:0] humid_count_reg, humid_count_next;
    logic [COUNT_WIDTH-1:0] press_count_reg, press_count_next;
    logic [COUNT_WIDTH-1:0] air_count_reg, air_count_next;

    logic                   accept;
    logic                   clock_run, humid_run, press_run, air_run;
    logic [REG_W-1:0]       humid_reload, press_reload;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    assign clock_run = !pulse_prev_reg && pulse_level;
    assign humid_run = (humid_count_reg == CNT_ONE);
    assign press_run = (press_count_reg == CNT_ONE);
    assign air_run   = (air_count_reg == CNT_ONE);

    always_comb
    begin
        case (humid_phase_reg)
            HPH_TEMP_START:  humid_reload = cfg.temp_convert_time;
            HPH_TEMP_READ:   humid_reload = cfg.temp_to_humid_gap;
            HPH_HUMID_START: humid_reload = cfg.humid_convert_time;
            HPH_HUMID_READ:  humid_reload = cfg.humid_cycle_period;
            default:         humid_reload = cfg.humid_cycle_period;
        endcase
        case (press_phase_reg)
            PPH_START: press_reload = cfg.pressure_convert_time;
            PPH_READ:  press_reload = cfg.pressure_cycle_period;
            default:   press_reload = cfg.pressure_cycle_period;
        endcase
    end

    always_comb
    begin
        pulse_prev_next  = pulse_prev_reg;
        humid_phase_next = humid_phase_reg;
        press_phase_next = press_phase_reg;
        humid_count_next = humid_count_reg;
        press_count_next = press_count_reg;
        air_count_next   = air_count_reg;
        if (accept)
        begin
            pulse_prev_next = pulse_level;
            // zero counter stays parked
            if (humid_count_reg != CNT_ZERO)
                humid_count_next = humid_count_reg - CNT_ONE;
            if (press_count_reg != CNT_ZERO)
                press_count_next = press_count_reg - CNT_ONE;
            if (air_count_reg != CNT_ZERO)
                air_count_next = air_count_reg - CNT_ONE;
            if (humid_run)
            begin
                humid_count_next = COUNT_WIDTH'(humid_reload);
                humid_phase_next = humid_phase_reg + 2'd1;
            end
            if (press_run)
            begin
                press_count_next = COUNT_WIDTH'(press_reload);
                press_phase_next = !press_phase_reg;
            end
            if (air_run)
                air_count_next = COUNT_WIDTH'(cfg.air_quality_period);
        end
    end

    always_comb
    begin
        push_job.run[RUN_CLOCK] = clock_run;
        push_job.run[RUN_HUMID] = humid_run;
        push_job.run[RUN_PRESS] = press_run;
        push_job.run[RUN_AIR]   = air_run;
        push_job.humid_cmd      = CMD_TEMP_START + {1'b0, humid_phase_reg};
        push_job.press_cmd      = CMD_PRESS_START + {2'b00, press_phase_reg};
    end

    // quiet ticks leave nothing for the back end
    assign push = accept && (clock_run || humid_run || press_run || air_run);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_prev_reg  <= 1'b0;
            humid_phase_reg <= HPH_TEMP_START;
            press_phase_reg <= PPH_START;
            humid_count_reg <= COUNT_WIDTH'(STARTUP_SENSOR);
            press_count_reg <= COUNT_WIDTH'(STARTUP_SENSOR);
            air_count_reg   <= COUNT_WIDTH'(STARTUP_AIR);
        end
        else
        begin
            pulse_prev_reg  <= pulse_prev_next;
            humid_phase_reg <= humid_phase_next;
            press_phase_reg <= press_phase_next;
            humid_count_reg <= humid_count_next;
            press_count_reg <= press_count_next;
            air_count_reg   <= air_count_next;
        end
    end

endmodule

// File: hdl/sps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module sps_queue
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t q_status
);

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_job       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/sps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_back
// command issue: walks a job's run mask; while out_stall is low, one command per cycle
// ----------------------------------------------------------------------------
module sps_back
    import sps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head_job,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] command,
    output logic       last
);

    job_t       work_reg, work_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] command_reg, command_next;
    logic       last_reg, last_next;

    logic       load_ok, issue;
    logic [3:0] pick, rest;
    logic [2:0] pick_cmd;

    assign load_ok = !out_valid_reg || !out_stall;
    assign issue   = load_ok && (work_reg.run != 4'b0000);

    // lowest pending bit goes first
    always_comb
    begin
        pick     = 4'b0000;
        pick_cmd = CMD_CLOCK_READ;
        if (work_reg.run[RUN_CLOCK])
        begin
            pick[RUN_CLOCK] = 1'b1;
            pick_cmd        = CMD_CLOCK_READ;
        end
        else if (work_reg.run[RUN_HUMID])
        begin
            pick[RUN_HUMID] = 1'b1;
            pick_cmd        = work_reg.humid_cmd;
        end
        else if (work_reg.run[RUN_PRESS])
        begin
            pick[RUN_PRESS] = 1'b1;
            pick_cmd        = work_reg.press_cmd;
        end
        else if (work_reg.run[RUN_AIR])
        begin
            pick[RUN_AIR] = 1'b1;
            pick_cmd      = CMD_AIR_READ;
        end
    end

    assign rest = work_reg.run & ~pick;

    always_comb
    begin
        work_next      = work_reg;
        out_valid_next = out_valid_reg;
        command_next   = command_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            out_valid_next = issue;
            if (issue)
            begin
                command_next  = pick_cmd;
                last_next     = (rest == 4'b0000);
                work_next.run = rest;
            end
        end
        // refill once the current job is spent
        if (work_next.run == 4'b0000 && !q_status.empty)
        begin
            pop       = 1'b1;
            work_next = head_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            work_reg      <= work_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign command   = command_reg;
    assign last      = last_reg;

endmodule
